// File: src/assert_macros.svh
// Assertion macros shared by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("box filter assertion failed");
`define BF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("box filter forbidden condition");
`else
`define BF_ASSERT(lbl, clk, rstn, prop)
`define BF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: src/bf2d_pkg.sv
// Types and constants of the box filter block.
package bf2d_pkg;

  localparam int RADIUS_W     = 4;
  localparam int FWIDTH_W     = 12;
  localparam int FHEIGHT_W    = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 13;
  localparam int PIX_FIELD_W  = 16;
  localparam int SUM_W        = 26;
  localparam int SIDE_W       = RADIUS_W + 1;
  localparam int CNT_W        = 2 * SIDE_W;
  localparam int NUM_W        = SUM_W + 2;
  localparam int DEN_W        = CNT_W + 1;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  localparam logic [1:0] REG_RADIUS    = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_NORMALIZE = 2'd3;

  typedef struct packed {
    logic                   kind;
    logic [PIX_FIELD_W-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             frame_end;
  } out_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } chain_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEM,
    S_ACC,
    S_CNT,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// File: src/bf2d_ram.sv
// Generic single write port RAM with registered read.
module bf2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bf2d_cell.sv
// One cell of the vertical sum chain: shifts forward on a new sum, rotates back when read.
module bf2d_cell #(
  parameter int WIDTH = 34
) (
  input  logic                   clk,
  input  bf2d_pkg::chain_ctl_t   ctl,
  input  logic [WIDTH-1:0]       left_d,
  input  logic [WIDTH-1:0]       right_d,
  output logic [WIDTH-1:0]       q
);

  logic [WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= left_d;
    end else if (ctl.rotate) begin
      data_r <= right_d;
    end
  end

  assign q = data_r;

endmodule

// File: src/bf2d_div.sv
// Restoring divider, one quotient bit per cycle.
module bf2d_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (32'(cnt_r) == NUM_W - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: src/box_filter_2d_running_sum_top.sv
// Box filter top level: one item at a time through column sums, a cell chain and a divider.
// Sequence: an item with a result passes S_MEM, S_ACC (one turn of the chain), S_CNT, then
// S_DSTART and S_DIV in normalize mode, and S_OUT, which loads the result register once the output
// is free; an item without a result returns to S_IDLE after S_MEM, and an early drain tick is ignored.
// The next item is taken once S_OUT has loaded the result and the sequencer is back in S_IDLE.
// Reset (synchronous, active low) restores register defaults and frame positions; no clearing.
`include "assert_macros.svh"
module box_filter_2d_running_sum_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bf2d_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bf2d_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bf2d_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bf2d_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bf2d_pkg::out_t                      out_data
);

  localparam int RW    = bf2d_pkg::RADIUS_W;
  localparam int ROWW  = bf2d_pkg::ROW_W;
  localparam int SUMW  = bf2d_pkg::SUM_W;
  localparam int SIDEW = bf2d_pkg::SIDE_W;
  localparam int CNTW  = bf2d_pkg::CNT_W;
  localparam int NUMW  = bf2d_pkg::NUM_W;
  localparam int DENW  = bf2d_pkg::DEN_W;
  localparam int DW    = bf2d_pkg::APB_DATA_W;
  localparam int HW    = bf2d_pkg::FHEIGHT_W;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int LRW   = $clog2(2 * MAX_RADIUS);
  localparam int CHAIN_LEN = 2 * MAX_RADIUS + 1;
  localparam int STW   = $clog2(CHAIN_LEN);
  localparam int VSW   = PIXEL_BITS + $clog2(CHAIN_LEN);
  localparam int CELLW = VSW + ROWW;
  localparam int TW    = CW + 13;
  localparam int DLW   = CW + RW + 1;
  localparam int PW    = CW + 14;
  localparam int LS_DEPTH = 2 * MAX_RADIUS * (2 ** CIW);

  bf2d_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]                    radius_r;
  logic [bf2d_pkg::FWIDTH_W-1:0]    fwidth_r;
  logic [HW-1:0]                    fheight_r;
  logic                             norm_r;
  logic                             cfg_wr;
  logic                             cfg_wr_q_r;

  logic [RW-1:0]   r_eff;
  logic [CW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [RW:0]     two_r;
  logic [TW-1:0]   total_r;
  logic [DLW-1:0]  delay_r;

  logic [PW-1:0]   pcnt_r;
  logic [ROWW-1:0] row_r;
  logic [CIW-1:0]  col_r;
  logic [LRW-1:0]  lsrow_r;
  logic [ROWW-1:0] orow_r;
  logic [CIW-1:0]  ocol_r;

  logic [PIXEL_BITS-1:0] v_r;
  logic [PW-1:0]         pcur_r;
  logic [SUMW-1:0]       sum_r;
  logic [STW-1:0]        step_r;
  logic [CNTW-1:0]       cnt_r;

  logic                  in_acc;
  logic                  in_frame;
  logic                  drop;
  logic                  mem_re;
  logic                  mem_we;
  logic                  div_start;
  logic                  div_done;
  logic                  out_load;
  logic                  last;
  logic                  step_last;
  logic                  acc_exit;
  bf2d_pkg::chain_ctl_t  chain_ctl;

  logic [VSW-1:0]        cs_rdata;
  logic [VSW-1:0]        cs_wdata;
  logic [PIXEL_BITS-1:0] ls_rdata;
  logic [VSW-1:0]        col_base;
  logic [PIXEL_BITS-1:0] old_pix;
  logic [VSW-1:0]        vsum;
  logic [CELLW-1:0]      chain_q [CHAIN_LEN];
  logic [VSW-1:0]        head_vsum;
  logic [ROWW-1:0]       head_tag;
  logic [ROWW-1:0]       vrow;
  logic                  take;

  logic [ROWW-1:0]       rlo, rhi, rows;
  logic [CW:0]           clo, chi, cols;
  logic [NUMW-1:0]       div_num;
  logic [DENW-1:0]       div_den;
  logic [NUMW-1:0]       div_quo;

  logic                  out_valid_r;
  bf2d_pkg::out_t        out_data_r;

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      bf2d_pkg::REG_RADIUS:    prdata = DW'(radius_r);
      bf2d_pkg::REG_WIDTH:     prdata = DW'(fwidth_r);
      bf2d_pkg::REG_HEIGHT:    prdata = DW'(fheight_r);
      bf2d_pkg::REG_NORMALIZE: prdata = DW'(norm_r);
      default:                 prdata = '0;
    endcase
  end

  assign r_eff = (32'(radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_r;
  assign w_eff = (fwidth_r == '0) ? CW'(1) :
                 ((32'(fwidth_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(fwidth_r));
  assign h_eff = (fheight_r == '0) ? HW'(1) :
                 ((32'(fheight_r) > bf2d_pkg::HEIGHT_LIMIT) ?
                  HW'(bf2d_pkg::HEIGHT_LIMIT) : fheight_r);
  assign two_r = {r_eff, 1'b0};

  // Handshake and item decisions.
  assign in_ready = (state_r == bf2d_pkg::S_IDLE) && !cfg_wr_q_r;
  assign in_acc   = in_valid && in_ready;
  assign in_frame = pcnt_r < PW'(total_r);
  assign drop     = in_data.kind && in_frame;
  assign mem_we   = (state_r == bf2d_pkg::S_MEM) && (r_eff != '0);

  // Vertical sums.
  assign col_base = (row_r == '0) ? '0 : cs_rdata;
  assign old_pix  = (row_r >= ROWW'(two_r)) ? ls_rdata : '0;
  assign vsum     = (r_eff == '0) ? VSW'(v_r) : VSW'(col_base + VSW'(v_r));
  assign cs_wdata = VSW'(vsum - VSW'(old_pix));

  bf2d_ram #(.WIDTH(VSW), .DEPTH(MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (mem_we),
    .waddr (col_r),
    .wdata (cs_wdata),
    .re    (mem_re),
    .raddr (col_r),
    .rdata (cs_rdata)
  );

  bf2d_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LS_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({lsrow_r, col_r}),
    .wdata (v_r),
    .re    (mem_re),
    .raddr ({lsrow_r, col_r}),
    .rdata (ls_rdata)
  );

  // Chain of cells holding the most recent vertical sums, newest in cell zero.
  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_chain
    logic [CELLW-1:0] left_d;
    logic [CELLW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = {vsum, row_r};
    end else begin : g_mid
      assign left_d = chain_q[i-1];
    end
    if (i == CHAIN_LEN - 1) begin : g_last
      assign right_d = chain_q[0];
    end else begin : g_inner
      assign right_d = chain_q[i+1];
    end
    bf2d_cell #(.WIDTH(CELLW)) u_cell (
      .clk     (clk),
      .ctl     (chain_ctl),
      .left_d  (left_d),
      .right_d (right_d),
      .q       (chain_q[i])
    );
  end

  assign head_vsum = chain_q[0][CELLW-1:ROWW];
  assign head_tag  = chain_q[0][ROWW-1:0];
  assign vrow      = ROWW'(orow_r + ROWW'(r_eff));
  assign step_last = 32'(step_r) == CHAIN_LEN - 1;
  assign take      = (32'(step_r) < 2 * 32'(r_eff) + 1) && (PW'(step_r) <= pcur_r) &&
                     (head_tag == vrow);

  // In-frame window size.
  assign rlo  = (orow_r > ROWW'(r_eff)) ? ROWW'(orow_r - ROWW'(r_eff)) : '0;
  assign rhi  = (ROWW'(orow_r + ROWW'(r_eff)) < ROWW'(h_eff)) ?
                ROWW'(orow_r + ROWW'(r_eff)) : ROWW'(h_eff - HW'(1));
  assign rows = ROWW'(rhi - rlo + ROWW'(1));
  assign clo  = (ocol_r > CIW'(r_eff)) ? (CW+1)'(ocol_r - CIW'(r_eff)) : '0;
  assign chi  = (((CW+1)'(ocol_r) + (CW+1)'(r_eff)) < (CW+1)'(w_eff)) ?
                ((CW+1)'(ocol_r) + (CW+1)'(r_eff)) : (CW+1)'(w_eff - CW'(1));
  assign cols = (CW+1)'(chi - clo + (CW+1)'(1));

  assign div_num = NUMW'({sum_r, 1'b0}) + NUMW'(cnt_r);
  assign div_den = {cnt_r, 1'b0};

  bf2d_div #(.NUM_W(NUMW), .DEN_W(DENW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign last = (orow_r == ROWW'(h_eff - HW'(1))) && (32'(ocol_r) + 1 == 32'(w_eff));
  assign acc_exit = (state_r == bf2d_pkg::S_ACC) && (state_nxt != bf2d_pkg::S_ACC);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bf2d_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    chain_ctl = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      bf2d_pkg::S_IDLE: begin
        if (in_acc && !drop) begin
          mem_re    = 1'b1;
          state_nxt = bf2d_pkg::S_MEM;
        end
      end
      bf2d_pkg::S_MEM: begin
        chain_ctl.shift = 1'b1;
        state_nxt = (pcnt_r >= PW'(delay_r)) ? bf2d_pkg::S_ACC : bf2d_pkg::S_IDLE;
      end
      bf2d_pkg::S_ACC: begin
        chain_ctl.rotate = 1'b1;
        if (step_last) begin
          state_nxt = bf2d_pkg::S_CNT;
        end
      end
      bf2d_pkg::S_CNT: begin
        state_nxt = norm_r ? bf2d_pkg::S_DSTART : bf2d_pkg::S_OUT;
      end
      bf2d_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_nxt = bf2d_pkg::S_DIV;
      end
      bf2d_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = bf2d_pkg::S_OUT;
        end
      end
      bf2d_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = bf2d_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bf2d_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration and frame position registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RW'(1);
      fwidth_r    <= bf2d_pkg::FWIDTH_W'(2048);
      fheight_r   <= HW'(4096);
      norm_r      <= 1'b1;
      cfg_wr_q_r  <= 1'b1;
      pcnt_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      lsrow_r     <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_wr_q_r <= cfg_wr;
      if (cfg_wr) begin
        case (paddr[3:2])
          bf2d_pkg::REG_RADIUS:    radius_r  <= pwdata[RW-1:0];
          bf2d_pkg::REG_WIDTH:     fwidth_r  <= pwdata[bf2d_pkg::FWIDTH_W-1:0];
          bf2d_pkg::REG_HEIGHT:    fheight_r <= pwdata[HW-1:0];
          bf2d_pkg::REG_NORMALIZE: norm_r    <= pwdata[0];
          default: ;
        endcase
      end
      if (cfg_wr || (out_load && last)) begin
        pcnt_r  <= '0;
        row_r   <= '0;
        col_r   <= '0;
        lsrow_r <= '0;
        orow_r  <= '0;
        ocol_r  <= '0;
      end else begin
        if (state_r == bf2d_pkg::S_MEM) begin
          pcnt_r <= pcnt_r + PW'(1);
          if (32'(col_r) + 1 >= 32'(w_eff)) begin
            col_r <= '0;
            row_r <= row_r + ROWW'(1);
            if (32'(lsrow_r) + 1 >= 32'(two_r)) begin
              lsrow_r <= '0;
            end else begin
              lsrow_r <= lsrow_r + LRW'(1);
            end
          end else begin
            col_r <= col_r + CIW'(1);
          end
        end
        if (out_load) begin
          if (32'(ocol_r) + 1 >= 32'(w_eff)) begin
            ocol_r <= '0;
            orow_r <= orow_r + ROWW'(1);
          end else begin
            ocol_r <= ocol_r + CIW'(1);
          end
        end
      end
      if (state_r == bf2d_pkg::S_ACC) begin
        step_r <= step_last ? '0 : step_r + STW'(1);
      end else begin
        step_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    total_r <= TW'(TW'(w_eff) * TW'(h_eff));
    delay_r <= DLW'(DLW'(r_eff) * DLW'(w_eff) + DLW'(r_eff));
    if (mem_re) begin
      v_r <= in_data.kind ? '0 : (in_frame ? PIXEL_BITS'(in_data.pixel) : '0);
    end
    if (state_r == bf2d_pkg::S_MEM) begin
      pcur_r <= pcnt_r;
      sum_r  <= '0;
    end else if ((state_r == bf2d_pkg::S_ACC) && take) begin
      sum_r <= SUMW'(sum_r + SUMW'(head_vsum));
    end
    if (state_r == bf2d_pkg::S_CNT) begin
      cnt_r <= CNTW'(SIDEW'(rows)) * CNTW'(SIDEW'(cols));
    end
    if (out_load) begin
      out_data_r.value     <= norm_r ? div_quo[SUMW-1:0] : sum_r;
      out_data_r.frame_end <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BF_ASSERT(a_out_no_overwrite, clk, rst_n, out_load |-> (!out_valid_r || out_ready))
  `BF_ASSERT(a_chain_full_turn, clk, rst_n, acc_exit |-> step_last)
  `BF_ASSERT(a_div_done_in_wait, clk, rst_n, div_done |-> (state_r == bf2d_pkg::S_DIV))
  `BF_ASSERT_NEVER(a_lsrow_range, clk, rst_n, (r_eff != '0) && (32'(lsrow_r) >= 32'(two_r)))

endmodule
